// ===== src/plti_pkg.sv =====
package plti_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);

	// Field widths fixed by the interface.
	localparam int IDX_W  = 8;
	localparam int E_W    = 24;
	localparam int F_W    = 32;
	localparam int CNT_W  = 9;
	localparam int OUT_W  = 34;
	localparam int SEG_W  = 8;

	// Arithmetic widths.
	localparam int DF_W     = F_W + 1;
	localparam int DE_W     = E_W + 1;
	localparam int NUM_W    = DF_W + DE_W;
	localparam int Q_W      = NUM_W + 1;
	localparam int SUM_W    = Q_W + 1;
	localparam int DIV_CNT_W = $clog2(NUM_W);
	localparam int WORD_W   = E_W + F_W;

	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic              load_wr;
		logic              query_start;
		logic [ADDR_W-1:0] rd_addr;
		logic              shift;
		logic              hit_cap;
		logic              above_cap;
		logic [ADDR_W-1:0] idx;
		logic              mul;
		logic              div_start;
		logic              sign;
		logic              out_load;
		logic              out_zero;
	} dp_cmd_t;

	typedef struct packed {
		logic hit;
		logic zero_width;
		logic div_done;
	} dp_stat_t;

endpackage

// ===== src/plti_ram.sv =====
module plti_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/plti_div.sv =====
module plti_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [plti_pkg::NUM_W-1:0]     dividend,
	input  logic [plti_pkg::DE_W-1:0]      divisor,
	output logic [plti_pkg::NUM_W-1:0]     quotient,
	output logic                           done
);

	// Restoring division, one quotient bit per cycle. The dividend shifts out
	// of the top of quo_q while quotient bits shift in at the bottom.
	logic [plti_pkg::NUM_W-1:0]     quo_q;
	logic [plti_pkg::DE_W-1:0]      rem_q;
	logic [plti_pkg::DE_W-1:0]      den_q;
	logic [plti_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic [plti_pkg::DE_W:0]        trial;
	logic [plti_pkg::DE_W:0]        diff;
	logic                           ge;

	assign trial = {rem_q, quo_q[plti_pkg::NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= plti_pkg::DIV_CNT_W'(plti_pkg::NUM_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - plti_pkg::DIV_CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[plti_pkg::DE_W-1:0] : trial[plti_pkg::DE_W-1:0];
			quo_q <= {quo_q[plti_pkg::NUM_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = busy_q && (cnt_q == '0);

endmodule

// ===== src/plti_dp.sv =====
module plti_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  plti_pkg::dp_cmd_t                 cmd,
	output plti_pkg::dp_stat_t                stat,
	input  logic [plti_pkg::IDX_W-1:0]        entry_index,
	input  logic [plti_pkg::E_W-1:0]          energy,
	input  logic [plti_pkg::F_W-1:0]          flux_value,
	output logic signed [plti_pkg::OUT_W-1:0] interpolated,
	output logic [plti_pkg::SEG_W-1:0]        segment,
	output logic                              above_range,
	output logic                              saturated
);

	logic                               ram_we;
	logic [plti_pkg::WORD_W-1:0]        rdata;
	logic [plti_pkg::E_W-1:0]           rd_e;
	logic [plti_pkg::F_W-1:0]           rd_f;

	logic [plti_pkg::E_W-1:0]           en_q;
	logic [plti_pkg::E_W-1:0]           prev_e_q;
	logic [plti_pkg::F_W-1:0]           prev_f_q;
	logic [plti_pkg::F_W-1:0]           f1_q;
	logic signed [plti_pkg::DF_W-1:0]   df_q;
	logic signed [plti_pkg::DE_W-1:0]   de_q;
	logic signed [plti_pkg::DE_W-1:0]   dw_q;
	logic signed [plti_pkg::NUM_W-1:0]  prod_q;
	logic                               neg_q;
	logic signed [plti_pkg::Q_W-1:0]    q_q;
	logic [plti_pkg::ADDR_W-1:0]        seg_cap_q;
	logic                               above_cap_q;

	logic signed [plti_pkg::OUT_W-1:0]  interp_q;
	logic [plti_pkg::SEG_W-1:0]         segment_q;
	logic                               above_q;
	logic                               sat_q;

	logic [plti_pkg::NUM_W-1:0]         num_mag;
	logic [plti_pkg::DE_W-1:0]          den_mag;
	logic [plti_pkg::NUM_W-1:0]         quot;
	logic                               div_done;
	logic signed [plti_pkg::SUM_W-1:0]  sum;
	logic [plti_pkg::SUM_W-plti_pkg::OUT_W:0] sum_top;
	logic                               in_range;

	assign ram_we = cmd.load_wr && (32'(entry_index) < plti_pkg::TABLE_DEPTH);

	plti_ram #(
		.WIDTH(plti_pkg::WORD_W),
		.DEPTH(plti_pkg::TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(plti_pkg::ADDR_W'(entry_index)),
		.wdata({energy, flux_value}),
		.raddr(cmd.rd_addr),
		.rdata(rdata)
	);

	assign rd_e = rdata[plti_pkg::WORD_W-1:plti_pkg::F_W];
	assign rd_f = rdata[plti_pkg::F_W-1:0];

	assign num_mag = prod_q[plti_pkg::NUM_W-1] ? plti_pkg::NUM_W'(-prod_q)
	                                           : plti_pkg::NUM_W'(prod_q);
	assign den_mag = dw_q[plti_pkg::DE_W-1] ? plti_pkg::DE_W'(-dw_q)
	                                        : plti_pkg::DE_W'(dw_q);

	plti_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(num_mag),
		.divisor (den_mag),
		.quotient(quot),
		.done    (div_done)
	);

	assign stat.hit        = en_q <= rd_e;
	assign stat.zero_width = dw_q == '0;
	assign stat.div_done   = div_done;

	always_ff @(posedge clk) begin
		if (cmd.query_start) begin
			en_q <= energy;
		end
		if (cmd.shift) begin
			prev_e_q <= rd_e;
			prev_f_q <= rd_f;
		end
		if (cmd.hit_cap) begin
			f1_q        <= prev_f_q;
			df_q        <= $signed({1'b0, rd_f}) - $signed({1'b0, prev_f_q});
			de_q        <= $signed({1'b0, en_q}) - $signed({1'b0, prev_e_q});
			dw_q        <= $signed({1'b0, rd_e}) - $signed({1'b0, prev_e_q});
			q_q         <= '0;
			seg_cap_q   <= cmd.idx;
			above_cap_q <= 1'b0;
		end
		if (cmd.above_cap) begin
			f1_q        <= rd_f;
			q_q         <= '0;
			seg_cap_q   <= cmd.idx;
			above_cap_q <= 1'b1;
		end
		if (cmd.mul) begin
			prod_q <= df_q * de_q;
		end
		if (cmd.div_start) begin
			neg_q <= prod_q[plti_pkg::NUM_W-1] ^ dw_q[plti_pkg::DE_W-1];
		end
		if (cmd.sign) begin
			q_q <= neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
		end
	end

	// Final sum, then clip to the 34-bit output range.
	assign sum      = plti_pkg::SUM_W'($signed({1'b0, f1_q})) + plti_pkg::SUM_W'(q_q);
	assign sum_top  = sum[plti_pkg::SUM_W-1:plti_pkg::OUT_W-1];
	assign in_range = (&sum_top) || !(|sum_top);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_zero) begin
				interp_q  <= '0;
				segment_q <= '0;
				above_q   <= 1'b0;
				sat_q     <= 1'b0;
			end else begin
				segment_q <= plti_pkg::SEG_W'(seg_cap_q);
				above_q   <= above_cap_q;
				sat_q     <= !in_range;
				if (in_range) begin
					interp_q <= sum[plti_pkg::OUT_W-1:0];
				end else if (sum[plti_pkg::SUM_W-1]) begin
					interp_q <= plti_pkg::OUT_MIN;
				end else begin
					interp_q <= plti_pkg::OUT_MAX;
				end
			end
		end
	end

	assign interpolated = interp_q;
	assign segment      = segment_q;
	assign above_range  = above_q;
	assign saturated    = sat_q;

endmodule

// ===== src/plti_ctrl.sv =====
module plti_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          cfg_we,
	input  logic [plti_pkg::CNT_W-1:0]    cfg_wdata,
	output plti_pkg::dp_cmd_t             cmd,
	input  plti_pkg::dp_stat_t            stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MUL,
		S_DSTART,
		S_DIV,
		S_SIGN,
		S_FINISH
	} state_t;

	state_t                       state_q;
	logic [plti_pkg::ADDR_W-1:0]  idx_q;
	logic [plti_pkg::ADDR_W-1:0]  last_q;
	logic [plti_pkg::CNT_W-1:0]   cfg_q;
	logic                         zero_q;
	logic                         out_valid_q;
	logic [31:0]                  n_used;

	// Clamp the configured count to the legal range of the table.
	always_comb begin
		n_used = 32'(cfg_q);
		if (n_used < 32'd2) begin
			n_used = 32'd2;
		end
		if (n_used > plti_pkg::TABLE_DEPTH) begin
			n_used = plti_pkg::TABLE_DEPTH;
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.idx     = idx_q;
		cmd.rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (op == plti_pkg::OP_LOAD) begin
						cmd.load_wr = 1'b1;
					end else begin
						cmd.query_start = 1'b1;
					end
				end
			end
			S_SCAN: begin
				cmd.shift   = 1'b1;
				cmd.rd_addr = idx_q + plti_pkg::ADDR_W'(1);
				if (idx_q != '0) begin
					if (stat.hit) begin
						cmd.hit_cap = 1'b1;
					end else if (idx_q == last_q) begin
						cmd.above_cap = 1'b1;
					end
				end
			end
			S_MUL: begin
				cmd.mul = !stat.zero_width;
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
			end
			S_SIGN: begin
				cmd.sign = 1'b1;
			end
			S_FINISH: begin
				cmd.out_load = !out_valid_q || out_ready;
				cmd.out_zero = zero_q;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			last_q      <= '0;
			cfg_q       <= plti_pkg::CNT_RESET;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (op == plti_pkg::OP_LOAD) begin
							zero_q  <= 1'b1;
							state_q <= S_FINISH;
						end else begin
							zero_q  <= 1'b0;
							idx_q   <= '0;
							last_q  <= plti_pkg::ADDR_W'(n_used - 32'd1);
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (idx_q != '0 && stat.hit) begin
						state_q <= S_MUL;
					end else if (idx_q != '0 && idx_q == last_q) begin
						state_q <= S_FINISH;
					end else begin
						idx_q <= idx_q + plti_pkg::ADDR_W'(1);
					end
				end
				S_MUL: begin
					state_q <= stat.zero_width ? S_FINISH : S_DSTART;
				end
				S_DSTART: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (stat.div_done) begin
						state_q <= S_SIGN;
					end
				end
				S_SIGN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

endmodule

// ===== src/piecewise_linear_table_interpolator.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_ready    op, entry_index, energy, flux_value
// output    out_valid / out_ready  interpolated, segment, above_range, saturated
// config    cfg_we                 cfg_wdata (entries in use)
//
// A load word passes through the finish state into the output register. A
// query scans the breakpoint memory up to the breakpoint that ends the scan:
// the memory is read one entry per cycle, and the division of the
// interpolation product retires one quotient bit per cycle (58 bits).
// Zero-width segments and queries above the table skip the divide.
// Reset clears control state only; the table holds garbage until loaded.
// A finished result waits in the output register, and the block takes the
// next input word while that result is still stalled.
module piecewise_linear_table_interpolator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              op,
	input  logic [plti_pkg::IDX_W-1:0]        entry_index,
	input  logic [plti_pkg::E_W-1:0]          energy,
	input  logic [plti_pkg::F_W-1:0]          flux_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [plti_pkg::OUT_W-1:0] interpolated,
	output logic [plti_pkg::SEG_W-1:0]        segment,
	output logic                              above_range,
	output logic                              saturated,
	input  logic                              cfg_we,
	input  logic [plti_pkg::CNT_W-1:0]        cfg_wdata
);

	// The controller sequences the scan, multiply, divide and output steps;
	// the datapath owns the breakpoint memory and all arithmetic.
	plti_pkg::dp_cmd_t  cmd;
	plti_pkg::dp_stat_t stat;

	plti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.stat     (stat)
	);

	plti_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.entry_index (entry_index),
		.energy      (energy),
		.flux_value  (flux_value),
		.interpolated(interpolated),
		.segment     (segment),
		.above_range (above_range),
		.saturated   (saturated)
	);

endmodule

// ===== src/plti_checker.sv =====
module plti_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [plti_pkg::OUT_W-1:0] interpolated,
	input logic [plti_pkg::SEG_W-1:0]        segment,
	input logic                              above_range,
	input logic                              saturated
);

	// Only one word is processed at a time, so the block is busy right after accepting.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a word was still in flight");

	// A clipped result always sits at one of the range limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			(interpolated == plti_pkg::OUT_MAX || interpolated == plti_pkg::OUT_MIN))
		else $error("saturated result is not at a range limit");

	// The last flux is returned unchanged above the table, so it never clips.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && above_range |-> !saturated)
		else $error("above-range result flagged as saturated");

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(interpolated) && $stable(segment))
		else $error("stalled result changed");

endmodule

bind piecewise_linear_table_interpolator plti_checker u_plti_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	// Shapes of breakpoint table that a phase may load.
	typedef enum int {
		SHAPE_RISING,
		SHAPE_FALLING,
		SHAPE_SCATTER,
		SHAPE_STAIRS
	} table_shape_t;

	// One input word as it waits in the stimulus queue.
	typedef struct packed {
		logic                       op;
		logic [plti_pkg::IDX_W-1:0] slot;
		logic [plti_pkg::E_W-1:0]   e;
		logic [plti_pkg::F_W-1:0]   f;
	} word_t;

	// One predicted output word.
	typedef struct packed {
		logic signed [plti_pkg::OUT_W-1:0] value;
		logic [plti_pkg::SEG_W-1:0]        seg;
		logic                              above;
		logic                              sat;
	} outcome_t;

	// A query can scan all 256 breakpoints and then run a 58-step divide. On top
	// of that come a full sender gap, a full receiver stall and the short pause
	// around a register write. The limit leaves a wide margin over all of that
	// together.
	localparam int QUIET_LIMIT = 4000;
	// Cycles to keep watching the output once every expected word has arrived.
	localparam int DRAIN_CYCLES = 400;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic                              op = plti_pkg::OP_LOAD;
	logic [plti_pkg::IDX_W-1:0]        entry_index = '0;
	logic [plti_pkg::E_W-1:0]          energy = '0;
	logic [plti_pkg::F_W-1:0]          flux_value = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic signed [plti_pkg::OUT_W-1:0] interpolated;
	logic [plti_pkg::SEG_W-1:0]        segment;
	logic                              above_range;
	logic                              saturated;
	logic                              cfg_we = 1'b0;
	logic [plti_pkg::CNT_W-1:0]        cfg_wdata = '0;

	// Words waiting to be driven, and results waiting to be seen.
	word_t    pending_words[$];
	outcome_t expected_outcomes[$];

	// The predictor's own copy of the table and of the entry count. These are
	// updated only when a word is accepted or the register is written.
	logic [plti_pkg::E_W-1:0]   bp_energy[plti_pkg::TABLE_DEPTH];
	logic [plti_pkg::F_W-1:0]   bp_flux[plti_pkg::TABLE_DEPTH];
	logic [plti_pkg::CNT_W-1:0] used_cnt = plti_pkg::CNT_RESET;

	// The generator's view of the energies it has queued, used to aim queries
	// at and around the breakpoints.
	logic [plti_pkg::E_W-1:0] planned_energy[plti_pkg::TABLE_DEPTH];

	// Percent chance per cycle of starting a burst of idling on either side.
	int idle_pct = 0;
	int stall_pct = 0;
	int gap_left = 0;
	int stall_left = 0;

	int errors = 0;
	int quiet_cycles = 0;
	int loads_done = 0;
	int queries_done = 0;
	int above_seen = 0;
	int sat_seen = 0;
	int settings_done = 0;

	piecewise_linear_table_interpolator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.entry_index (entry_index),
		.energy      (energy),
		.flux_value  (flux_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.interpolated(interpolated),
		.segment     (segment),
		.above_range (above_range),
		.saturated   (saturated),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The block clamps the entry count into the range 2 to TABLE_DEPTH.
	function automatic int effective_entries(input logic [plti_pkg::CNT_W-1:0] raw);
		if (raw < 2)
			return 2;
		if (raw > plti_pkg::TABLE_DEPTH)
			return plti_pkg::TABLE_DEPTH;
		return int'(raw);
	endfunction

	// Works out the answer to a query from the current table. The scan starts
	// at the second breakpoint and stops at the first one whose energy is at
	// or above the query; the result is then the straight line through that
	// breakpoint and the one before it. When no breakpoint is high enough the
	// last flux is returned and the word is flagged above range. Differences
	// are signed, so a descending table or a query below the first segment
	// extrapolates, and a zero-width segment returns its lower flux.
	function automatic outcome_t interpolate_flux(input logic [plti_pkg::E_W-1:0] e);
		outcome_t res;
		int       n;
		bit       hit;
		longint   e_lo;
		longint   e_hi;
		longint   f_lo;
		longint   f_hi;
		longint   acc;
		res = '0;
		hit = 1'b0;
		n = effective_entries(used_cnt);
		res.seg = plti_pkg::SEG_W'(n - 1);
		res.above = 1'b1;
		acc = longint'(bp_flux[n - 1]);
		for (int i = 1; i < n && !hit; i++) begin
			if (e <= bp_energy[i]) begin
				hit = 1'b1;
				e_lo = longint'(bp_energy[i - 1]);
				e_hi = longint'(bp_energy[i]);
				f_lo = longint'(bp_flux[i - 1]);
				f_hi = longint'(bp_flux[i]);
				res.seg = plti_pkg::SEG_W'(i);
				res.above = 1'b0;
				if (e_hi == e_lo)
					acc = f_lo;
				else
					acc = f_lo + (f_hi - f_lo) * (longint'(e) - e_lo) / (e_hi - e_lo);
			end
		end
		if (acc > longint'(plti_pkg::OUT_MAX)) begin
			acc = longint'(plti_pkg::OUT_MAX);
			res.sat = 1'b1;
		end else if (acc < longint'(plti_pkg::OUT_MIN)) begin
			acc = longint'(plti_pkg::OUT_MIN);
			res.sat = 1'b1;
		end
		res.value = acc[plti_pkg::OUT_W-1:0];
		return res;
	endfunction

	// Fluxes lean toward the two extremes so that steep slopes and saturation
	// come up often, but every bit still sees both values.
	function automatic logic [plti_pkg::F_W-1:0] pick_flux();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return plti_pkg::F_W'($urandom);
		endcase
	endfunction

	task automatic push_load(input logic [plti_pkg::IDX_W-1:0] slot,
		input logic [plti_pkg::E_W-1:0] e, input logic [plti_pkg::F_W-1:0] f);
		word_t w;
		w.op = plti_pkg::OP_LOAD;
		w.slot = slot;
		w.e = e;
		w.f = f;
		planned_energy[slot] = e;
		pending_words.push_back(w);
	endtask

	task automatic push_query(input logic [plti_pkg::E_W-1:0] e);
		word_t w;
		w.op = plti_pkg::OP_QUERY;
		w.slot = plti_pkg::IDX_W'($urandom);
		w.e = e;
		w.f = plti_pkg::F_W'($urandom);
		pending_words.push_back(w);
	endtask

	// Returns at a falling edge once every queued word has been accepted and
	// every expected result has come back. Every word yields a result, so the
	// block is idle at that point; a few spare cycles are added anyway.
	task automatic settle();
		@(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_outcomes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Writes the entry count while the block is idle and updates the
	// predictor's copy at the same time.
	task automatic set_entries(input logic [plti_pkg::CNT_W-1:0] raw);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= raw;
		used_cnt = raw;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		settings_done++;
	endtask

	// One phase: wait for idle, set the entry count, optionally load a fresh
	// table into every slot in use, then issue mostly queries aimed at the
	// breakpoints with some loose loads mixed in. Queries are only issued once
	// every slot in use has been written.
	task automatic run_phase(input logic [plti_pkg::CNT_W-1:0] raw,
		input table_shape_t shape, input bit reload, input int n_words,
		input int gap_pct, input int hold_pct);
		int                       n;
		int                       acc;
		int                       max_step;
		int                       j;
		int                       lo;
		int                       hi;
		logic [plti_pkg::E_W-1:0] steps[plti_pkg::TABLE_DEPTH];
		logic [plti_pkg::E_W-1:0] e;
		settle();
		set_entries(raw);
		idle_pct = gap_pct;
		stall_pct = hold_pct;
		n = effective_entries(raw);
		if (reload) begin
			// Build an ascending run of energies first; a falling table is the
			// same run loaded back to front.
			acc = $urandom_range(4096);
			max_step = (int'({plti_pkg::E_W{1'b1}}) - acc) / n;
			for (int i = 0; i < n; i++) begin
				steps[i] = plti_pkg::E_W'(acc);
				if (shape == SHAPE_STAIRS && $urandom_range(2) == 0)
					acc = acc;
				else
					acc = acc + $urandom_range(max_step);
			end
			for (int i = 0; i < n; i++) begin
				case (shape)
					SHAPE_FALLING: e = steps[n - 1 - i];
					SHAPE_SCATTER: e = plti_pkg::E_W'($urandom);
					default: e = steps[i];
				endcase
				push_load(plti_pkg::IDX_W'(i), e, pick_flux());
			end
		end
		for (int k = 0; k < n_words; k++) begin
			j = $urandom_range(n - 1);
			case ($urandom_range(9))
				0, 1, 2: push_query(planned_energy[j]);
				3, 4: push_query($urandom_range(1) ? planned_energy[j] + 1'b1
					: planned_energy[j] - 1'b1);
				5, 6: push_query(plti_pkg::E_W'($urandom));
				7: push_query($urandom_range(1) ? '0 : '1);
				8: begin
					// A stray load leaves slots in use written, so queries
					// stay within what the table holds.
					push_load(plti_pkg::IDX_W'($urandom), plti_pkg::E_W'($urandom),
						pick_flux());
				end
				default: begin
					j = $urandom_range(n - 1, 1);
					lo = int'(planned_energy[j - 1]);
					hi = int'(planned_energy[j]);
					if (lo > hi)
						push_query(plti_pkg::E_W'($urandom_range(lo, hi)));
					else
						push_query(plti_pkg::E_W'($urandom_range(hi, lo)));
				end
			endcase
		end
	endtask

	// Driver. An accepted word is handed to the predictor at the edge that
	// takes it. A new word, or a burst of idling, is chosen only when the
	// current word has gone or nothing is offered, so valid never drops while
	// a word is waiting and the payload never changes under it.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				if (op == plti_pkg::OP_LOAD) begin
					bp_energy[entry_index] = energy;
					bp_flux[entry_index] = flux_value;
					expected_outcomes.push_back('0);
					loads_done++;
				end else begin
					expected_outcomes.push_back(interpolate_flux(energy));
					queries_done++;
				end
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0 && $urandom_range(99) < idle_pct) begin
					gap_left = $urandom_range(6);
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					in_valid <= 1'b1;
					op <= pending_words[0].op;
					entry_index <= pending_words[0].slot;
					energy <= pending_words[0].e;
					flux_value <= pending_words[0].f;
					pending_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Every accepted output word is checked field by field against
	// the oldest prediction. Back-pressure comes in bursts.
	always @(posedge clk) begin
		outcome_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid === 1'b1 && out_ready) begin
				if (expected_outcomes.size() == 0) begin
					$error("output word with nothing expected: interpolated %0d, segment %0d",
						interpolated, segment);
					errors++;
				end else begin
					want = expected_outcomes.pop_front();
					if (want.above)
						above_seen++;
					if (want.sat)
						sat_seen++;
					if (interpolated !== want.value) begin
						$error("interpolated: expected %0d, got %0d", $signed(want.value),
							interpolated);
						errors++;
					end
					if (segment !== want.seg) begin
						$error("segment: expected %0d, got %0d", want.seg, segment);
						errors++;
					end
					if (above_range !== want.above) begin
						$error("above_range: expected %0b, got %0b", want.above, above_range);
						errors++;
					end
					if (saturated !== want.sat) begin
						$error("saturated: expected %0b, got %0b", want.sat, saturated);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(99) < stall_pct) begin
				stall_left = $urandom_range(6);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run when no word moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid === 1'b1 && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
			$display("** piecewise_linear_table_interpolator: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		idle_pct = 20;
		stall_pct = 20;

		// Directed words with the reset count of two entries.
		// A segment spanning the full energy range: both ends and the middle.
		push_load(plti_pkg::IDX_W'(0), '0, '0);
		push_load(plti_pkg::IDX_W'(1), '1, '1);
		push_query('0);
		push_query('1);
		push_query(24'h80_0000);
		// A short table, so the top of the energy range lies above it.
		push_load(plti_pkg::IDX_W'(1), 24'h01_0000, 32'h0001_0000);
		push_query('1);
		push_query(24'h00_8000);
		// Two breakpoints at the same energy must not divide.
		push_load(plti_pkg::IDX_W'(0), 24'h01_0000, 32'h1234_5678);
		push_query(24'h01_0000);
		push_query('0);
		// Extrapolating far below a steep first segment clips high, then low.
		push_load(plti_pkg::IDX_W'(0), 24'hFF_FFFE, '1);
		push_load(plti_pkg::IDX_W'(1), '1, '0);
		push_query('0);
		push_load(plti_pkg::IDX_W'(0), 24'hFF_FFFE, '0);
		push_load(plti_pkg::IDX_W'(1), '1, '1);
		push_query('0);
		// A descending pair: below, on, and above the upper breakpoint.
		push_load(plti_pkg::IDX_W'(0), 24'h80_0000, 32'h0010_0000);
		push_load(plti_pkg::IDX_W'(1), 24'h40_0000, 32'h0020_0000);
		push_query(24'h20_0000);
		push_query(24'h40_0000);
		push_query(24'h90_0000);
		// The top slot; not read while only two entries are in use.
		push_load(8'hFF, 24'h5A_5A5A, 32'hA5A5_A5A5);

		// Random phases over several table sizes, including counts that the
		// block clamps. Slots 0 to 255 are all loaded before any phase whose
		// count reaches the full depth without reloading.
		run_phase(plti_pkg::CNT_W'(3), SHAPE_RISING, 1'b1, 20, 25, 25);
		run_phase(plti_pkg::CNT_W'(17), SHAPE_STAIRS, 1'b1, 25, 0, 0);
		run_phase(plti_pkg::CNT_W'(256), SHAPE_RISING, 1'b1, 30, 20, 40);
		run_phase(plti_pkg::CNT_W'(511), SHAPE_RISING, 1'b0, 15, 35, 10);
		run_phase(plti_pkg::CNT_W'(0), SHAPE_FALLING, 1'b1, 15, 10, 30);
		run_phase(plti_pkg::CNT_W'(1), SHAPE_SCATTER, 1'b1, 15, 40, 0);
		run_phase(plti_pkg::CNT_W'(24), SHAPE_FALLING, 1'b1, 15, 15, 15);
		run_phase(plti_pkg::CNT_W'(300), SHAPE_RISING, 1'b0, 15, 30, 30);
		run_phase(plti_pkg::CNT_W'(9), SHAPE_SCATTER, 1'b1, 20, 20, 50);
		// The closing phase runs without any idling on either side.
		run_phase(plti_pkg::CNT_W'(2), SHAPE_STAIRS, 1'b1, 25, 0, 0);

		settle();
		// Keep watching for stray output words after the last result.
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d breakpoint loads and %0d queries over %0d entry-count settings.",
			loads_done, queries_done, settings_done);
		$display("Queries above the table: %0d; clipped results: %0d.", above_seen, sat_seen);
		if (errors == 0) begin
			$display("** piecewise_linear_table_interpolator: PASSED **");
		end else begin
			$display("** piecewise_linear_table_interpolator: FAILED **");
		end
		$finish;
	end

endmodule

// ===== piecewise_linear_table_interpolator.f =====
src/plti_pkg.sv
src/plti_ram.sv
src/plti_div.sv
src/plti_dp.sv
src/plti_ctrl.sv
src/piecewise_linear_table_interpolator.sv
src/plti_checker.sv
tb/sv/testbench.sv
